>>> hw/rtl/double_ended_queue_unit_macros.svh
// ============================================================================
// Double-ended queue unit assertion macros
// Shared assertion wrappers that compile away when SYNTH is defined.
// ============================================================================
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/deq_pkg.sv
// ============================================================================
// Double-ended queue package
// Shared constants, codes and controller-to-datapath types.
// ============================================================================
package deq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IO_VALUE_W      = 32;
    localparam int IO_COUNT_W      = 5;
    localparam int IO_STATUS_W     = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [IO_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_POP   = 2'd0,
        RD_FRONT = 2'd1,
        RD_BACK  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    exec;
        logic    cap_pop;
        logic    cap_front;
        logic    cap_back;
        logic    load_out;
        t_rd_sel rd_sel;
    } t_dp_ctrl;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

>>> hw/rtl/deq_in_if.sv
// ============================================================================
// Double-ended queue command channel
// Valid/ready channel that carries one queue operation per item.
// ============================================================================
interface deq_in_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic                                   at_front;
    logic signed [deq_pkg::IO_VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output at_front, output value, input ready);
    modport sink   (input valid, input cmd, input at_front, input value, output ready);

endinterface

>>> hw/rtl/deq_out_if.sv
// ============================================================================
// Double-ended queue result channel
// Valid/ready channel that carries one result per operation.
// ============================================================================
interface deq_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [deq_pkg::IO_VALUE_W-1:0]  popped_value;
    logic signed [deq_pkg::IO_VALUE_W-1:0]  front_value;
    logic signed [deq_pkg::IO_VALUE_W-1:0]  back_value;
    logic        [deq_pkg::IO_COUNT_W-1:0]  count;
    logic        [deq_pkg::IO_STATUS_W-1:0] status;

    modport source (output valid, output popped_value, output front_value,
                    output back_value, output count, output status, input ready);
    modport sink   (input valid, input popped_value, input front_value,
                    input back_value, input count, input status, output ready);

endinterface

>>> hw/rtl/deq_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module deq_ram #(
    parameter int WIDTH = deq_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/deq_ctrl.sv
// ============================================================================
// Double-ended queue controller
// Sequences each operation through execute, three reads and result hand-off.
// ============================================================================
`include "double_ended_queue_unit_macros.svh"

module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_FRONT,
        S_RD_BACK,
        S_CAP_BACK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_ctrl           = '0;
        o_ctrl.rd_sel    = deq_pkg::RD_POP;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = i_rst_n;
                o_ctrl.load = i_in_valid && i_rst_n;
                if (o_ctrl.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec   = 1'b1;
                o_ctrl.rd_sel = deq_pkg::RD_POP;
                n_state       = S_RD_FRONT;
            end
            S_RD_FRONT: begin
                o_ctrl.cap_pop = 1'b1;
                o_ctrl.rd_sel  = deq_pkg::RD_FRONT;
                n_state        = S_RD_BACK;
            end
            S_RD_BACK: begin
                o_ctrl.cap_front = 1'b1;
                o_ctrl.rd_sel    = deq_pkg::RD_BACK;
                n_state          = S_CAP_BACK;
            end
            S_CAP_BACK: begin
                o_ctrl.cap_back = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `DEQ_ASSERT(a_one_step, i_clk, i_rst_n, $onehot0({o_ctrl.exec, o_ctrl.cap_pop, o_ctrl.cap_front, o_ctrl.cap_back, o_ctrl.load_out}), "More than one datapath step at once.")
    `DEQ_ASSERT(a_accept_exec, i_clk, i_rst_n, (o_in_ready && i_in_valid) |=> o_ctrl.exec, "Accepted item was not executed next.")
    `DEQ_ASSERT(a_exec_then_pop, i_clk, i_rst_n, o_ctrl.exec |=> o_ctrl.cap_pop, "Pop read did not follow execute.")

endmodule

>>> hw/rtl/deq_datapath.sv
// ============================================================================
// Double-ended queue datapath
// Head and count registers, ring store, result capture and output register.
// ============================================================================
`include "double_ended_queue_unit_macros.svh"

module deq_datapath #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  deq_pkg::t_dp_ctrl                      i_ctrl,
    output deq_pkg::t_dp_stat                      o_stat,
    input  logic                                   i_cmd,
    input  logic                                   i_at_front,
    input  logic        [deq_pkg::IO_VALUE_W-1:0]  i_value,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic        [deq_pkg::IO_VALUE_W-1:0]  o_popped_value,
    output logic        [deq_pkg::IO_VALUE_W-1:0]  o_front_value,
    output logic        [deq_pkg::IO_VALUE_W-1:0]  o_back_value,
    output logic        [deq_pkg::IO_COUNT_W-1:0]  o_count,
    output logic        [deq_pkg::IO_STATUS_W-1:0] o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int OW = deq_pkg::IO_VALUE_W;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [OW-1:0] f_to_out(input logic [VW-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[OW-1:0];
    endfunction

    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_cmd;
    logic             r_front;
    logic [VW-1:0]    r_value;
    deq_pkg::t_status r_status;
    deq_pkg::t_status n_status;
    logic [VW-1:0]    r_popped;
    logic [VW-1:0]    r_fv;
    logic [VW-1:0]    r_bv;
    logic             r_out_valid;
    logic [OW-1:0]    r_out_popped;
    logic [OW-1:0]    r_out_front;
    logic [OW-1:0]    r_out_back;
    logic [deq_pkg::IO_COUNT_W-1:0]  r_out_count;
    logic [deq_pkg::IO_STATUS_W-1:0] r_out_status;

    logic             is_empty;
    logic             is_full;
    logic [CW-1:0]    last_off;
    logic [AW-1:0]    back_addr;
    logic [AW-1:0]    pop_addr;
    logic [AW-1:0]    push_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [VW-1:0]    ram_rdata;

    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CW'(DEPTH));
    assign last_off  = r_count - CW'(1);
    assign back_addr = f_wrap(r_head, last_off);
    assign pop_addr  = r_front ? r_head : back_addr;
    assign push_addr = r_front ? f_wrap(r_head, CW'(DEPTH - 1)) : f_wrap(r_head, r_count);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        ram_we   = 1'b0;
        if (r_cmd == deq_pkg::CMD_POP) begin
            if (is_empty) begin
                n_status = deq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - CW'(1);
                if (r_front) begin
                    n_head = f_wrap(r_head, CW'(1));
                end
            end
        end else begin
            if (is_full) begin
                n_status = deq_pkg::ST_FULL;
            end else begin
                ram_we  = i_ctrl.exec;
                n_count = r_count + CW'(1);
                if (r_front) begin
                    n_head = push_addr;
                end
            end
        end
    end

    always_comb begin
        case (i_ctrl.rd_sel)
            deq_pkg::RD_POP:   ram_raddr = pop_addr;
            deq_pkg::RD_FRONT: ram_raddr = r_head;
            deq_pkg::RD_BACK:  ram_raddr = back_addr;
            default:           ram_raddr = r_head;
        endcase
    end

    deq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (push_addr),
        .i_wdata (r_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_front <= i_at_front;
            r_value <= VW'(i_value);
        end
        if (i_ctrl.exec) begin
            r_status <= n_status;
        end
        if (i_ctrl.cap_pop) begin
            r_popped <= (r_cmd == deq_pkg::CMD_POP && r_status == deq_pkg::ST_OK) ?
                        ram_rdata : '0;
        end
        if (i_ctrl.cap_front) begin
            r_fv <= is_empty ? '0 : ram_rdata;
        end
        if (i_ctrl.cap_back) begin
            r_bv <= is_empty ? '0 : ram_rdata;
        end
        if (i_ctrl.load_out) begin
            r_out_popped <= f_to_out(r_popped);
            r_out_front  <= f_to_out(r_fv);
            r_out_back   <= f_to_out(r_bv);
            r_out_count  <= deq_pkg::IO_COUNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_popped_value  = r_out_popped;
    assign o_front_value   = r_out_front;
    assign o_back_value    = r_out_back;
    assign o_count         = r_out_count;
    assign o_status        = r_out_status;

    `DEQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "Element count exceeds depth.")
    `DEQ_ASSERT(a_head_bound, i_clk, i_rst_n, r_head <= AW'(DEPTH - 1), "Head index out of range.")
    `DEQ_ASSERT(a_count_hold, i_clk, i_rst_n, !i_ctrl.exec |=> $stable(r_count) && $stable(r_head), "Queue pointers moved without an operation.")
    `DEQ_ASSERT(a_full_reject, i_clk, i_rst_n, (i_ctrl.exec && r_cmd == deq_pkg::CMD_PUSH && is_full) |=> (r_status == deq_pkg::ST_FULL) && $stable(r_count), "Push to full queue was not rejected.")

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// ============================================================================
// Double-ended queue unit
// Bounded deque of values in a ring store, pushed and popped at either end.
// ============================================================================
// Each command item pushes or pops one value at the front or back end and
// yields one result item with the popped value, the front and back values,
// the new count and a status (ok, pop from empty, push to full). A failed
// operation leaves the queue unchanged, and front and back read as zero when
// the queue is empty. An item passes through execute, the pop, front and back
// reads and the capture of the back value before its result is loaded into the
// output register, and the next item is accepted only after that, because the
// ring store has a single read port that serves three reads per item (popped,
// front and back); a waiting result stalls the next item only at its final
// step. There is no clearing pass after reset.
module double_ended_queue_unit #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    deq_in_if.sink   i_in,
    deq_out_if.source o_out
);

    deq_pkg::t_dp_ctrl ctrl;
    deq_pkg::t_dp_stat stat;
    logic              in_ready;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    deq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_cmd          (i_in.cmd),
        .i_at_front     (i_in.at_front),
        .i_value        (i_in.value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_popped_value (o_out.popped_value),
        .o_front_value  (o_out.front_value),
        .o_back_value   (o_out.back_value),
        .o_count        (o_out.count),
        .o_status       (o_out.status)
    );

    assign i_in.ready = in_ready;

endmodule

>>> dv/tb_double_ended_queue_unit.sv
// ============================================================================
// Double-ended queue unit testbench
// Drives push and pop items at both ends of the queue, checks every result
// against an in-bench model of the ring store or a written expectation, and
// applies random idling, a long result stall that backs up the command channel,
// and a full drain.
module tb_double_ended_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH      = deq_pkg::DEPTH_DEF;
    localparam int VW          = deq_pkg::IO_VALUE_W;
    localparam int CNTW        = deq_pkg::IO_COUNT_W;
    localparam int RANDOM_OPS  = 800;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [VW-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic signed [VW-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [VW-1:0] popped;
        logic signed [VW-1:0] front;
        logic signed [VW-1:0] back;
        logic [CNTW-1:0]      count;
        deq_pkg::t_status     status;
    } t_result;

    typedef struct packed {
        logic                 cmd;
        logic                 at_front;
        logic signed [VW-1:0] value;
        logic                 typed;
        t_result              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    deq_in_if  in_if ();
    deq_out_if out_if ();

    double_ended_queue_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    logic signed [VW-1:0] slot_mem [QDEPTH];
    int                   front_idx;
    int                   held;
    t_result              pending_results [$];
    t_row                 directed_rows [$];
    int                   mismatches;
    int                   cycles;
    bit                   sender_steady;
    bit                   receiver_steady;
    bit                   stall_request;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic t_result apply_deque_op(logic cmd, logic at_front,
                                               logic signed [VW-1:0] value);
        t_result r;
        r.popped = '0;
        r.status = deq_pkg::ST_OK;
        if (cmd == deq_pkg::CMD_POP) begin
            if (held == 0) begin
                r.status = deq_pkg::ST_EMPTY;
            end else if (at_front) begin
                r.popped  = slot_mem[front_idx];
                front_idx = (front_idx + 1) % QDEPTH;
                held--;
            end else begin
                r.popped = slot_mem[(front_idx + held - 1) % QDEPTH];
                held--;
            end
        end else begin
            if (held >= QDEPTH) begin
                r.status = deq_pkg::ST_FULL;
            end else if (at_front) begin
                front_idx           = (front_idx + QDEPTH - 1) % QDEPTH;
                slot_mem[front_idx] = value;
                held++;
            end else begin
                slot_mem[(front_idx + held) % QDEPTH] = value;
                held++;
            end
        end
        r.count = CNTW'(held);
        r.front = '0;
        r.back  = '0;
        if (held != 0) begin
            r.front = slot_mem[front_idx];
            r.back  = slot_mem[(front_idx + held - 1) % QDEPTH];
        end
        return r;
    endfunction

    function automatic void add_row(logic cmd, logic at_front,
                                    logic signed [VW-1:0] value, logic typed,
                                    logic signed [VW-1:0] popped,
                                    logic signed [VW-1:0] front,
                                    logic signed [VW-1:0] back,
                                    int count, deq_pkg::t_status status);
        t_row row;
        row.cmd         = cmd;
        row.at_front    = at_front;
        row.value       = value;
        row.typed       = typed;
        row.want.popped = popped;
        row.want.front  = front;
        row.want.back   = back;
        row.want.count  = CNTW'(count);
        row.want.status = status;
        directed_rows.push_back(row);
    endfunction

    task automatic offer_item(input t_row row);
        t_result predicted;
        if (!sender_steady && $urandom_range(99) < 33) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.cmd      <= row.cmd;
        in_if.at_front <= row.at_front;
        in_if.value    <= row.value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = apply_deque_op(row.cmd, row.at_front, row.value);
        pending_results.push_back(row.typed ? row.want : predicted);
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin : result_sink
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= receiver_steady || ($urandom_range(99) >= 33);
        end
    end

    initial begin : result_check
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result item arrived with no expectation waiting");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_if.popped_value !== want.popped) begin
                        $error("popped_value expected %0d got %0d",
                               want.popped, out_if.popped_value);
                        mismatches++;
                    end
                    if (out_if.front_value !== want.front) begin
                        $error("front_value expected %0d got %0d",
                               want.front, out_if.front_value);
                        mismatches++;
                    end
                    if (out_if.back_value !== want.back) begin
                        $error("back_value expected %0d got %0d",
                               want.back, out_if.back_value);
                        mismatches++;
                    end
                    if (out_if.count !== want.count) begin
                        $error("count expected %0d got %0d", want.count, out_if.count);
                        mismatches++;
                    end
                    if (out_if.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, out_if.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_row row;
        int   push_pct;
        int   kind;

        mismatches      = 0;
        front_idx       = 0;
        held            = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        stall_request   = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.cmd       = deq_pkg::CMD_PUSH;
        in_if.at_front  = 1'b0;
        in_if.value     = '0;

        // Both ends on an empty queue, the value extremes, and a push to empty
        // at either end, followed by a fill to the limit and pushes past it.
        add_row(deq_pkg::CMD_POP,  1'b1, '0, 1'b1, '0, '0, '0, 0, deq_pkg::ST_EMPTY);
        add_row(deq_pkg::CMD_POP,  1'b0, 32'h1234_5678, 1'b1, '0, '0, '0, 0,
                deq_pkg::ST_EMPTY);
        add_row(deq_pkg::CMD_PUSH, 1'b1, VAL_MAX, 1'b1, '0, VAL_MAX, VAL_MAX, 1,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH, 1'b0, VAL_MIN, 1'b1, '0, VAL_MAX, VAL_MIN, 2,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_POP,  1'b0, '0, 1'b1, VAL_MIN, VAL_MAX, VAL_MAX, 1,
                deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_POP,  1'b1, '1, 1'b1, VAL_MAX, '0, '0, 0, deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH, 1'b0, -1, 1'b1, '0, -1, -1, 1, deq_pkg::ST_OK);
        add_row(deq_pkg::CMD_PUSH, 1'b1, '0, 1'b1, '0, '0, -1, 2, deq_pkg::ST_OK);
        for (int i = 0; i < QDEPTH - 2; i++) begin
            add_row(deq_pkg::CMD_PUSH, i[0], 32'h0101_0101 * (i + 1), 1'b0,
                    '0, '0, '0, 0, deq_pkg::ST_OK);
        end
        add_row(deq_pkg::CMD_PUSH, 1'b1, 5,  1'b0, '0, '0, '0, 0, deq_pkg::ST_FULL);
        add_row(deq_pkg::CMD_PUSH, 1'b0, -5, 1'b0, '0, '0, '0, 0, deq_pkg::ST_FULL);
        add_row(deq_pkg::CMD_POP,  1'b1, '0, 1'b0, '0, '0, '0, 0, deq_pkg::ST_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i]);
        end

        push_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                kind = int'($urandom_range(2));
                push_pct = (kind == 0) ? 15 : (kind == 1) ? 50 : 85;
            end
            sender_steady   = (n >= 150 && n < 300) || (n >= 500 && n < 530);
            receiver_steady = (n >= 150 && n < 300);
            if (n == 500) begin
                stall_request = 1'b1;
            end
            if (n == 650) begin
                wait_for_drain();
            end
            row.cmd      = ($urandom_range(99) < push_pct) ? deq_pkg::CMD_PUSH
                                                           : deq_pkg::CMD_POP;
            row.at_front = 1'($urandom_range(1));
            kind         = int'($urandom_range(3));
            if (kind == 0) begin
                row.value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
            end else if (kind == 1) begin
                row.value = $signed(32'($urandom_range(32))) - 16;
            end else begin
                row.value = $urandom;
            end
            row.typed = 1'b0;
            row.want  = '0;
            offer_item(row);
        end

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
